FILE: hdl/mpas_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio sync and duration package
// Shared widths, codes, command and status types and the bitrate tables.
// ----------------------------------------------------------------------------
package mpas_pkg;

   // Field widths.
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned KBPS_W     = 9;
   localparam int unsigned DUR_W      = 23;
   localparam int unsigned STATUS_W   = 2;

   // One kbit/s for one second is taken as 128 bytes, so the byte count is shifted down first.
   localparam int unsigned BYTES_SHIFT = 7;
   localparam int unsigned DIVIDEND_W  = WORD_W - BYTES_SHIFT;
   localparam int unsigned DIV_STEPS   = DIVIDEND_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int unsigned REM_W       = KBPS_W;

   // Header pattern constants.
   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_MASK = 8'hE0;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NO_SYNC  = 2'd1,
      STATUS_BAD_RATE = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_SCAN,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // an input transaction is accepted
      logic load_now;   // load a result that needs no division
      logic div_start;  // capture header fields and seed the divider
      logic div_step;   // one restoring division step
      logic load_div;   // load the result of a finished division
   } cmd_type;

   // Status from the datapath to the controller, valid with the offered item.
   typedef struct packed {
      logic hit_now;    // item gives a result without division
      logic hit_div;    // item gives a result that needs division
   } stat_type;

   // Layer III bitrate in kbit/s; zero marks the free and forbidden indices.
   function automatic logic [KBPS_W-1:0] rate_lookup(input logic mpeg1,
                                                     input logic [3:0] idx);
      logic [KBPS_W-1:0] rate;
      if (mpeg1) begin
         case (idx)
            4'd1:    rate = 9'd32;
            4'd2:    rate = 9'd40;
            4'd3:    rate = 9'd48;
            4'd4:    rate = 9'd56;
            4'd5:    rate = 9'd64;
            4'd6:    rate = 9'd80;
            4'd7:    rate = 9'd96;
            4'd8:    rate = 9'd112;
            4'd9:    rate = 9'd128;
            4'd10:   rate = 9'd160;
            4'd11:   rate = 9'd192;
            4'd12:   rate = 9'd224;
            4'd13:   rate = 9'd256;
            4'd14:   rate = 9'd320;
            default: rate = '0;
         endcase
      end else begin
         case (idx)
            4'd1:    rate = 9'd8;
            4'd2:    rate = 9'd16;
            4'd3:    rate = 9'd24;
            4'd4:    rate = 9'd32;
            4'd5:    rate = 9'd40;
            4'd6:    rate = 9'd48;
            4'd7:    rate = 9'd56;
            4'd8:    rate = 9'd64;
            4'd9:    rate = 9'd80;
            4'd10:   rate = 9'd96;
            4'd11:   rate = 9'd112;
            4'd12:   rate = 9'd128;
            4'd13:   rate = 9'd144;
            4'd14:   rate = 9'd160;
            default: rate = '0;
         endcase
      end
      return rate;
   endfunction

endpackage

FILE: hdl/mpas_if.sv
// ----------------------------------------------------------------------------
// MPEG audio sync and duration channel interfaces
// Valid/ready channels for file bytes in and header reports out.
// ----------------------------------------------------------------------------
interface mpas_req_if;
   import mpas_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first;
   logic              last;

   modport source(output valid, output data_byte, output first, output last,
                  input ready);
   modport sink(input valid, input data_byte, input first, input last,
                output ready);
endinterface

interface mpas_rsp_if;
   import mpas_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   header_offset;
   logic [KBPS_W-1:0]   bitrate_kbps;
   logic                is_mpeg1;
   logic [DUR_W-1:0]    duration_seconds;

   modport source(output valid, output status, output header_offset,
                  output bitrate_kbps, output is_mpeg1, output duration_seconds,
                  input ready);
   modport sink(input valid, input status, input header_offset,
                input bitrate_kbps, input is_mpeg1, input duration_seconds,
                output ready);
endinterface

FILE: hdl/mpeg_audio_sync_and_duration_top.sv
// A not-found or invalid-bitrate result is valid in the cycle after its byte.
// A found result with a valid bitrate waits for the divide and load states.
// Throughput: one byte per cycle while scanning and the output is free; a sync
// with a valid bitrate pauses input for the 25-step serial divider and result load.
// Reset is synchronous and active high: it empties the scan window, zeroes the byte
// position and file size, and drops the output valid.
// ----------------------------------------------------------------------------
// MPEG audio sync and duration top level
// Finds the first MPEG audio frame header in a byte stream and reports its
// offset, bitrate and an estimated playing time.
// ----------------------------------------------------------------------------
module mpeg_audio_sync_and_duration_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [mpas_pkg::WORD_W-1:0] csr_write_data,
   mpas_req_if.sink                    req_bus,
   mpas_rsp_if.source                  rsp_bus
);
   import mpas_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencing of transactions and the divider.
   mpas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Scan, decode, division and result storage.
   mpas_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_data_byte        (req_bus.data_byte),
      .req_first            (req_bus.first),
      .req_last             (req_bus.last),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_status           (rsp_bus.status),
      .rsp_header_offset    (rsp_bus.header_offset),
      .rsp_bitrate_kbps     (rsp_bus.bitrate_kbps),
      .rsp_is_mpeg1         (rsp_bus.is_mpeg1),
      .rsp_duration_seconds (rsp_bus.duration_seconds)
   );

endmodule

FILE: hdl/mpas_ctrl.sv
// ----------------------------------------------------------------------------
// MPEG audio sync and duration controller
// Sequences byte acceptance, the bit-serial division and result loading.
// ----------------------------------------------------------------------------
module mpas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mpas_pkg::stat_type stat,
   output mpas_pkg::cmd_type  cmd
);
   import mpas_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;
   logic                   accept;
   logic                   last_step;

   // The output register can take a result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign last_step = (count_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (accept && stat.hit_div) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (last_step) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_SCAN: begin
            req_ready     = out_free;
            cmd.take      = accept;
            cmd.load_now  = accept && stat.hit_now;
            cmd.div_start = accept && stat.hit_div;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_LOAD: begin
            cmd.load_div = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Step counter and output valid flag.
   always_comb begin
      count_in = (state_ff == ST_DIVIDE) ? count_ff + DIV_CNT_W'(1) : '0;
      if (cmd.load_now || cmd.load_div) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/mpas_datapath.sv
// ----------------------------------------------------------------------------
// MPEG audio sync and duration datapath
// Byte window, position count, header decode, divider and result register.
// ----------------------------------------------------------------------------
module mpas_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [mpas_pkg::WORD_W-1:0]   csr_write_data,
   input  logic [mpas_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_first,
   input  logic                          req_last,
   input  mpas_pkg::cmd_type             cmd,
   output mpas_pkg::stat_type            stat,
   output logic [mpas_pkg::STATUS_W-1:0] rsp_status,
   output logic [mpas_pkg::WORD_W-1:0]   rsp_header_offset,
   output logic [mpas_pkg::KBPS_W-1:0]   rsp_bitrate_kbps,
   output logic                          rsp_is_mpeg1,
   output logic [mpas_pkg::DUR_W-1:0]    rsp_duration_seconds
);
   import mpas_pkg::*;

   // Scan state.
   logic [WORD_W-1:0]     file_size_ff;
   logic [BYTE_W-1:0]     window_ff [3];
   logic [WORD_W-1:0]     pos_ff;
   logic                  done_ff;

   // Scan state as seen by the offered byte, after a new-file restart.
   logic [BYTE_W-1:0]     win0, win1, win2;
   logic [WORD_W-1:0]     eff_pos;
   logic                  eff_done;

   // Header decode.
   logic                  sync_hit;
   logic                  mpeg1;
   logic [KBPS_W-1:0]     kbps;
   logic [WORD_W-1:0]     offset;
   logic [WORD_W-1:0]     diff;

   // Divider and held header fields.
   logic [WORD_W-1:0]     hold_offset_ff;
   logic [KBPS_W-1:0]     hold_kbps_ff;
   logic                  hold_mpeg1_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [REM_W:0]        trial;
   logic [REM_W:0]        trial_sub;
   logic                  trial_ge;

   // Result register.
   logic [STATUS_W-1:0]   status_ff;
   logic [WORD_W-1:0]     offset_ff;
   logic [KBPS_W-1:0]     kbps_ff;
   logic                  mpeg1_ff;
   logic [DUR_W-1:0]      dur_ff;

   // A first byte restarts the scan before the byte itself is examined.
   always_comb begin
      win0     = req_first ? '0 : window_ff[0];
      win1     = req_first ? '0 : window_ff[1];
      win2     = req_first ? '0 : window_ff[2];
      eff_pos  = req_first ? '0 : pos_ff;
      eff_done = req_first ? 1'b0 : done_ff;
   end

   // The three held bytes form the header once the fourth byte arrives.
   always_comb begin
      sync_hit = !eff_done && (win0 == SYNC_BYTE) && ((win1 & SYNC_MASK) == SYNC_MASK);
      mpeg1    = win1[3];
      kbps     = rate_lookup(mpeg1, win2[7:4]);
      offset   = eff_pos - WORD_W'(3);
      diff     = (file_size_ff >= offset) ? file_size_ff - offset : '0;
      stat.hit_div = sync_hit && (kbps != '0);
      stat.hit_now = (sync_hit && (kbps == '0)) || (!eff_done && !sync_hit && req_last);
   end

   // Configuration register and scan state.
   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
         window_ff[0] <= '0;
         window_ff[1] <= '0;
         window_ff[2] <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            file_size_ff <= csr_write_data;
         end
         if (cmd.take && !eff_done) begin
            window_ff[0] <= win1;
            window_ff[1] <= win2;
            window_ff[2] <= req_data_byte;
            pos_ff       <= eff_pos + WORD_W'(1);
            done_ff      <= sync_hit || req_last;
         end
      end
   end

   // One restoring step: shift in a dividend bit, subtract the rate if it fits.
   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_ge  = (trial >= {1'b0, hold_kbps_ff});
      trial_sub = trial - {1'b0, hold_kbps_ff};
   end

   // Divider registers and held header fields.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         hold_offset_ff <= offset;
         hold_kbps_ff   <= kbps;
         hold_mpeg1_ff  <= mpeg1;
         quo_ff         <= diff[WORD_W-1:BYTES_SHIFT];
         rem_ff         <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_now) begin
         status_ff <= sync_hit ? STATUS_BAD_RATE : STATUS_NO_SYNC;
         offset_ff <= sync_hit ? offset : '0;
         kbps_ff   <= '0;
         mpeg1_ff  <= sync_hit && mpeg1;
         dur_ff    <= '0;
      end else if (cmd.load_div) begin
         status_ff <= STATUS_FOUND;
         offset_ff <= hold_offset_ff;
         kbps_ff   <= hold_kbps_ff;
         mpeg1_ff  <= hold_mpeg1_ff;
         dur_ff    <= quo_ff[DUR_W-1:0] + DUR_W'(1);
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_header_offset    = offset_ff;
   assign rsp_bitrate_kbps     = kbps_ff;
   assign rsp_is_mpeg1         = mpeg1_ff;
   assign rsp_duration_seconds = dur_ff;

endmodule

FILE: hdl/mpas_checker.sv
// ----------------------------------------------------------------------------
// MPEG audio sync and duration checker
// Port-level assertions on result consistency, attached to the top level.
// ----------------------------------------------------------------------------
module mpas_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mpas_pkg::STATUS_W-1:0] rsp_status,
   input logic [mpas_pkg::WORD_W-1:0]   rsp_header_offset,
   input logic [mpas_pkg::KBPS_W-1:0]   rsp_bitrate_kbps,
   input logic [mpas_pkg::DUR_W-1:0]    rsp_duration_seconds
);
   import mpas_pkg::*;

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered with the same status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result dropped or changed");

   // A found header always carries a bitrate and a nonzero time.
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FOUND)) |->
      ((rsp_bitrate_kbps != '0) && (rsp_duration_seconds != '0)))
      else $error("found result without bitrate or duration");

   // A missing header reports nothing else.
   a_no_sync_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NO_SYNC)) |->
      ((rsp_header_offset == '0) && (rsp_bitrate_kbps == '0) &&
       (rsp_duration_seconds == '0)))
      else $error("not-found result with nonzero fields");

   // An invalid bitrate index gives no bitrate and no time.
   a_bad_rate_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_BAD_RATE)) |->
      ((rsp_bitrate_kbps == '0) && (rsp_duration_seconds == '0)))
      else $error("invalid-bitrate result with nonzero bitrate or duration");

endmodule

bind mpeg_audio_sync_and_duration_top mpas_checker u_mpas_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_status           (rsp_bus.status),
   .rsp_header_offset    (rsp_bus.header_offset),
   .rsp_bitrate_kbps     (rsp_bus.bitrate_kbps),
   .rsp_duration_seconds (rsp_bus.duration_seconds)
);
